// File: rtl/lsfe_pkg.sv
package lsfe_pkg;

	typedef enum logic [2:0] {
		K_SET_ONE = 3'd0,
		K_SET_ALL = 3'd1,
		K_CLEAR   = 3'd2,
		K_ROT_CCW = 3'd3,
		K_ROT_CW  = 3'd4,
		K_SHOW    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_BAD_LEVEL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		FS_IDLE,
		FS_SCALE,
		FS_WRITE_ONE,
		FS_FILL,
		FS_ROT_RD,
		FS_ROT_TMP,
		FS_ROT_MOVE,
		FS_ROT_LAST,
		FS_RESP,
		FS_SHOW_HEAD,
		FS_SHOW_LED,
		FS_SHOW_TAIL
	} fsm_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_SQ,
		SC_CUBE,
		SC_OFS,
		SC_MUL,
		SC_DIV,
		SC_REM,
		SC_RND
	} sc_state_t;

	localparam logic [19:0] SCALE_DEN = 20'd1000000;
	localparam logic [19:0] SCALE_OFS = 20'd2000;
	// x / 15625 == (x * DEN_RECIP) >> 36 for x below 2^22; SCALE_DEN is 64 * 15625
	localparam logic [22:0] DEN_RECIP = 23'd4398047;
	localparam logic [6:0]  MAX_LEVEL = 7'd100;
	localparam logic [2:0]  LED_HDR   = 3'b111;
	localparam logic [4:0]  LED_COUNT_RST = 5'd12;

endpackage

// File: rtl/lsfe_ram.sv
module lsfe_ram #(
	parameter int WIDTH  = 24,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/lsfe_scale.sv
module lsfe_scale import lsfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] rgb,
	input  logic [6:0]  level,
	output logic        done,
	output logic [23:0] result
);

	sc_state_t   state_q, state_d;
	logic [6:0]  lvl_q;
	logic [23:0] rgb_q;
	logic [19:0] acc_q;
	logic [27:0] rem_q;
	logic [7:0]  quo_q;
	logic [1:0]  ch_q;
	logic [23:0] res_q;
	logic        done_q;

	logic [22:0] mul_a;
	logic [21:0] mul_b;
	logic [44:0] prod;
	logic [7:0]  chan;
	logic [19:0] ofs_sum;
	logic [20:0] twice;
	logic        rnd_up;
	logic [7:0]  rnd_byte;

	always_comb begin
		case (ch_q)
			2'd0:    chan = rgb_q[7:0];
			2'd1:    chan = rgb_q[15:8];
			2'd2:    chan = rgb_q[23:16];
			default: chan = 8'd0;
		endcase
	end

	// one shared multiplier: L*L, L^2*L, channel * factor, reciprocal, quotient * 1e6
	always_comb begin
		mul_a = 23'd0;
		mul_b = 22'd0;
		unique case (state_q)
			SC_SQ: begin
				mul_a = {16'd0, lvl_q};
				mul_b = {15'd0, lvl_q};
			end
			SC_CUBE: begin
				mul_a = {3'd0, acc_q};
				mul_b = {15'd0, lvl_q};
			end
			SC_MUL: begin
				mul_a = {3'd0, acc_q};
				mul_b = {14'd0, chan};
			end
			SC_DIV: begin
				mul_a = DEN_RECIP;
				mul_b = rem_q[27:6];
			end
			SC_REM: begin
				mul_a = {3'd0, SCALE_DEN};
				mul_b = {14'd0, quo_q};
			end
			default: begin
				mul_a = 23'd0;
				mul_b = 22'd0;
			end
		endcase
	end

	assign prod     = {22'd0, mul_a} * {23'd0, mul_b};
	assign ofs_sum  = rem_q[19:0] + SCALE_OFS;
	assign twice    = {rem_q[19:0], 1'b0};
	assign rnd_up   = (twice > {1'b0, SCALE_DEN}) ||
		((twice == {1'b0, SCALE_DEN}) && quo_q[0]);
	assign rnd_byte = quo_q + {7'd0, rnd_up};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE: begin
				if (start && (level != 7'd0)) begin
					state_d = SC_SQ;
				end
			end
			SC_SQ:   state_d = SC_CUBE;
			SC_CUBE: state_d = SC_OFS;
			SC_OFS:  state_d = SC_MUL;
			SC_MUL:  state_d = SC_DIV;
			SC_DIV:  state_d = SC_REM;
			SC_REM:  state_d = SC_RND;
			SC_RND: begin
				state_d = (ch_q == 2'd2) ? SC_IDLE : SC_MUL;
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == SC_IDLE) && start && (level == 7'd0)) ||
				((state_q == SC_RND) && (ch_q == 2'd2));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SC_IDLE: begin
				if (start) begin
					lvl_q <= level;
					rgb_q <= rgb;
					ch_q  <= 2'd0;
					res_q <= 24'd0;
				end
			end
			SC_SQ:   acc_q <= prod[19:0];
			SC_CUBE: rem_q <= prod[27:0];
			SC_OFS:  acc_q <= (ofs_sum > SCALE_DEN) ? SCALE_DEN : ofs_sum;
			SC_MUL:  rem_q <= prod[27:0];
			SC_DIV:  quo_q <= prod[43:36];
			SC_REM:  rem_q <= rem_q - prod[27:0];
			SC_RND: begin
				res_q[{ch_q, 3'b000} +: 8] <= rnd_byte;
				ch_q <= ch_q + 2'd1;
			end
			default: begin
				ch_q <= ch_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: rtl/led_strip_frame_engine_core.sv
// Accept to result: set one runs the shared scaler (setup, then each channel), then the
// store write and report; set all scales, then writes each entry below led_count.
// Bad index or brightness reports directly; brightness 0 skips the scaler math.
// Show: one word per cycle, led_count + 2 items, limited by the output handshake.
// One command at a time; s_axis_tready is high only between commands.
// Reset: colours read as zero through per-entry valid flags, led_count is 12 (or MAX_LEDS if smaller).
module led_strip_frame_engine_core import lsfe_pkg::*; #(
	parameter int MAX_LEDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// led_index[3:0], rgb[27:4], brightness[34:28], global_brightness[39:35]
	input  logic [39:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// frame_word[31:0], byte_count[34:32], status[36:35], zero fill above
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [4:0] CNT_RST = (MAX_LEDS < 12) ? 5'(MAX_LEDS) : LED_COUNT_RST;

	fsm_t          state_q, state_d;
	logic [4:0]    led_count_q;
	logic [MAX_LEDS-1:0] valid_q;
	logic          rd_vld_q;
	logic [3:0]    idx_q;
	logic [4:0]    gb_q;
	logic          set_all_q;
	logic          dir_q;
	status_t       status_q;
	logic [4:0]    cnt_q;
	logic [4:0]    cur_q;
	logic [4:0]    src_q;
	logic [23:0]   tmp_q;

	logic          m_valid_q;
	logic [31:0]   m_word_q;
	logic [2:0]    m_bytes_q;
	logic          m_last_q;
	status_t       m_status_q;

	kind_t         in_kind;
	logic          s_fire;
	logic          can_load;
	logic          idx_bad;
	logic          lvl_bad;
	logic [4:0]    n_m1;
	logic [4:0]    rot_start;
	logic [4:0]    rot_end;
	logic [4:0]    cur_nxt;
	logic [4:0]    src_nxt;
	logic [5:0]    trail_sum;
	logic          cnt_more;

	logic          scl_start;
	logic          scl_done;
	logic [23:0]   scl_result;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [23:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [23:0]   ram_q;
	logic [23:0]   rdata;

	logic          load_out;
	logic [31:0]   out_word;
	logic [2:0]    out_bytes;
	logic          out_last;
	status_t       out_status;

	assign in_kind   = kind_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == FS_IDLE);
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign can_load  = !m_valid_q || m_axis_tready;
	assign idx_bad   = {1'b0, s_axis_tdata[3:0]} >= led_count_q;
	assign lvl_bad   = s_axis_tdata[34:28] > MAX_LEVEL;
	assign n_m1      = led_count_q - 5'd1;
	assign rot_start = (in_kind == K_ROT_CW) ? n_m1 : 5'd0;
	assign rot_end   = dir_q ? 5'd0 : n_m1;
	assign cur_nxt   = dir_q ? (cur_q - 5'd1) : (cur_q + 5'd1);
	assign src_nxt   = dir_q ? (src_q - 5'd1) : (src_q + 5'd1);
	assign trail_sum = {1'b0, led_count_q} + 6'd15;
	assign cnt_more  = (cnt_q + 5'd1) < led_count_q;
	assign rdata     = rd_vld_q ? ram_q : 24'd0;

	assign scl_start = s_fire && !lvl_bad &&
		(((in_kind == K_SET_ONE) && !idx_bad) || (in_kind == K_SET_ALL));

	lsfe_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scl_start),
		.rgb    (s_axis_tdata[27:4]),
		.level  (s_axis_tdata[34:28]),
		.done   (scl_done),
		.result (scl_result)
	);

	lsfe_ram #(
		.WIDTH  (24),
		.DEPTH  (MAX_LEDS),
		.ADDR_W (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_q)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (s_fire) begin
					case (in_kind)
						K_SET_ONE: state_d = (idx_bad || lvl_bad) ? FS_RESP : FS_SCALE;
						K_SET_ALL: state_d = lvl_bad ? FS_RESP : FS_SCALE;
						K_CLEAR:   state_d = FS_RESP;
						K_ROT_CCW, K_ROT_CW: state_d = FS_ROT_RD;
						K_SHOW:    state_d = FS_SHOW_HEAD;
						default:   state_d = FS_IDLE;
					endcase
				end
			end
			FS_SCALE: begin
				if (scl_done) begin
					state_d = set_all_q ? FS_FILL : FS_WRITE_ONE;
				end
			end
			FS_WRITE_ONE: state_d = FS_RESP;
			FS_FILL: begin
				if (!cnt_more) begin
					state_d = FS_RESP;
				end
			end
			FS_ROT_RD:  state_d = FS_ROT_TMP;
			FS_ROT_TMP: state_d = (cur_q == rot_end) ? FS_ROT_LAST : FS_ROT_MOVE;
			FS_ROT_MOVE: begin
				if (src_q == rot_end) begin
					state_d = FS_ROT_LAST;
				end
			end
			FS_ROT_LAST: state_d = FS_RESP;
			FS_RESP: begin
				if (can_load) begin
					state_d = FS_IDLE;
				end
			end
			FS_SHOW_HEAD: begin
				if (can_load) begin
					state_d = FS_SHOW_LED;
				end
			end
			FS_SHOW_LED: begin
				if (can_load && !cnt_more) begin
					state_d = FS_SHOW_TAIL;
				end
			end
			FS_SHOW_TAIL: begin
				if (can_load) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = 24'd0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		load_out   = 1'b0;
		out_word   = 32'd0;
		out_bytes  = 3'd0;
		out_last   = 1'b0;
		out_status = STAT_OK;
		unique case (state_q)
			FS_IDLE: begin
				rd_en   = s_fire;
				rd_addr = AW'(rot_start);
			end
			FS_WRITE_ONE: begin
				wr_en   = 1'b1;
				wr_addr = AW'(idx_q);
				wr_data = scl_result;
			end
			FS_FILL: begin
				wr_en   = 1'b1;
				wr_addr = AW'(cnt_q);
				wr_data = scl_result;
			end
			FS_ROT_TMP: begin
				rd_en   = (cur_q != rot_end);
				rd_addr = AW'(cur_nxt);
			end
			FS_ROT_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = AW'(cur_q);
				wr_data = rdata;
				rd_en   = (src_q != rot_end);
				rd_addr = AW'(src_nxt);
			end
			FS_ROT_LAST: begin
				wr_en   = 1'b1;
				wr_addr = AW'(cur_q);
				wr_data = tmp_q;
			end
			FS_RESP: begin
				load_out   = can_load;
				out_last   = 1'b1;
				out_status = status_q;
			end
			FS_SHOW_HEAD: begin
				load_out  = can_load;
				out_bytes = 3'd4;
				rd_en     = can_load;
				rd_addr   = '0;
			end
			FS_SHOW_LED: begin
				load_out  = can_load;
				out_word  = {LED_HDR, gb_q, rdata};
				out_bytes = 3'd4;
				rd_en     = can_load && cnt_more;
				rd_addr   = AW'(cnt_q + 5'd1);
			end
			FS_SHOW_TAIL: begin
				load_out  = can_load;
				out_bytes = {1'b0, trail_sum[5:4]};
				out_last  = 1'b1;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			led_count_q <= CNT_RST;
			valid_q     <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				if (cfg_wr_data == 5'd0) begin
					led_count_q <= 5'd1;
				end else if (int'(cfg_wr_data) > MAX_LEDS) begin
					led_count_q <= 5'(MAX_LEDS);
				end else begin
					led_count_q <= cfg_wr_data;
				end
			end
			if (s_fire && (in_kind == K_CLEAR)) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_vld_q <= valid_q[rd_addr];
		end
		if (load_out) begin
			m_word_q   <= out_word;
			m_bytes_q  <= out_bytes;
			m_last_q   <= out_last;
			m_status_q <= out_status;
		end
		unique case (state_q)
			FS_IDLE: begin
				if (s_fire) begin
					idx_q     <= s_axis_tdata[3:0];
					gb_q      <= s_axis_tdata[39:35];
					set_all_q <= (in_kind == K_SET_ALL);
					dir_q     <= (in_kind == K_ROT_CW);
					cur_q     <= rot_start;
					cnt_q     <= 5'd0;
					if ((in_kind == K_SET_ONE) && idx_bad) begin
						status_q <= STAT_BAD_INDEX;
					end else if (((in_kind == K_SET_ONE) || (in_kind == K_SET_ALL)) &&
						lvl_bad) begin
						status_q <= STAT_BAD_LEVEL;
					end else begin
						status_q <= STAT_OK;
					end
				end
			end
			FS_FILL: cnt_q <= cnt_q + 5'd1;
			FS_ROT_TMP: begin
				tmp_q <= rdata;
				src_q <= cur_nxt;
			end
			FS_ROT_MOVE: begin
				cur_q <= src_q;
				src_q <= src_nxt;
			end
			FS_SHOW_LED: begin
				if (can_load) begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {3'd0, m_status_q, m_bytes_q, m_word_q};

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FS_IDLE) |-> !wr_en)
		else $error("store write while idle");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (m_status_q != STAT_OK)) |-> ((m_bytes_q == 3'd0) && m_last_q))
		else $error("fault report carries frame bytes");

	a_scale_done: assert property (@(posedge clk) disable iff (!arst_n)
		scl_done |-> (state_q == FS_SCALE))
		else $error("scaler finished outside scale wait");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(led_count_q != 5'd0) && (int'(led_count_q) <= MAX_LEDS))
		else $error("led_count out of range");

endmodule

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lsfe_pkg::*;

	localparam int STRIP_MAX = 16;
	localparam logic [2:0] KIND_RSVD_LO = 3'd6;
	localparam logic [2:0] KIND_RSVD_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  idx;
		logic [23:0] rgb;
		logic [6:0]  lvl;
		logic [4:0]  gbright;
	} led_cmd_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		status_t     status;
	} strip_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	led_cmd_t    cmd_backlog[$];
	led_cmd_t    cmd_on_bus;
	strip_word_t words_due[$];
	strip_word_t due_word;
	logic [23:0] shadow_colours [STRIP_MAX];
	int unsigned shadow_count = 12;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned fail_count = 0;

	led_strip_frame_engine_core #(.MAX_LEDS(STRIP_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// c * min(L^3 + 2000, 1e6) / 1e6, round half to even
	function automatic logic [7:0] dim_channel(logic [7:0] c, logic [6:0] lvl);
		int unsigned l, f, prod, q, r;
		if (lvl == 0)
			return 8'd0;
		l = lvl;
		f = l * l * l + SCALE_OFS;
		if (f > SCALE_DEN)
			f = SCALE_DEN;
		prod = c * f;
		q = prod / SCALE_DEN;
		r = prod % SCALE_DEN;
		if (2 * r > SCALE_DEN || (2 * r == SCALE_DEN && q[0]))
			q++;
		return q[7:0];
	endfunction

	function automatic logic [23:0] dim_colour(logic [23:0] rgb, logic [6:0] lvl);
		return {dim_channel(rgb[23:16], lvl), dim_channel(rgb[15:8], lvl),
			dim_channel(rgb[7:0], lvl)};
	endfunction

	function automatic void push_status(status_t st);
		words_due.push_back('{word: 32'd0, nbytes: 3'd0, last: 1'b1, status: st});
	endfunction

	// updates the shadow store and queues the words this item should produce
	function automatic void apply_cmd(led_cmd_t c);
		logic [23:0] tmp;
		int unsigned n;
		n = shadow_count;
		case (c.kind)
			K_SET_ONE: begin
				if (c.idx >= n)
					push_status(STAT_BAD_INDEX);
				else if (c.lvl > MAX_LEVEL)
					push_status(STAT_BAD_LEVEL);
				else begin
					shadow_colours[c.idx] = dim_colour(c.rgb, c.lvl);
					push_status(STAT_OK);
				end
			end
			K_SET_ALL: begin
				if (c.lvl > MAX_LEVEL)
					push_status(STAT_BAD_LEVEL);
				else begin
					tmp = dim_colour(c.rgb, c.lvl);
					for (int i = 0; i < n; i++)
						shadow_colours[i] = tmp;
					push_status(STAT_OK);
				end
			end
			K_CLEAR: begin
				for (int i = 0; i < STRIP_MAX; i++)
					shadow_colours[i] = '0;
				push_status(STAT_OK);
			end
			K_ROT_CCW: begin
				tmp = shadow_colours[0];
				for (int i = 0; i + 1 < n; i++)
					shadow_colours[i] = shadow_colours[i + 1];
				shadow_colours[n - 1] = tmp;
				push_status(STAT_OK);
			end
			K_ROT_CW: begin
				tmp = shadow_colours[n - 1];
				for (int i = n - 1; i > 0; i--)
					shadow_colours[i] = shadow_colours[i - 1];
				shadow_colours[0] = tmp;
				push_status(STAT_OK);
			end
			K_SHOW: begin
				words_due.push_back('{word: 32'd0, nbytes: 3'd4, last: 1'b0, status: STAT_OK});
				for (int i = 0; i < n; i++)
					words_due.push_back('{word: {LED_HDR, c.gbright, shadow_colours[i]},
						nbytes: 3'd4, last: 1'b0, status: STAT_OK});
				words_due.push_back('{word: 32'd0, nbytes: 3'((n + 15) / 16), last: 1'b1,
					status: STAT_OK});
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_cmd(logic [2:0] kind, logic [3:0] idx, logic [23:0] rgb,
			logic [6:0] lvl, logic [4:0] gbright);
		cmd_backlog.push_back('{kind: kind, idx: idx, rgb: rgb, lvl: lvl, gbright: gbright});
	endfunction

	function automatic led_cmd_t rand_cmd();
		led_cmd_t c;
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 30)
			c.kind = K_SET_ONE;
		else if (pick < 45)
			c.kind = K_SET_ALL;
		else if (pick < 50)
			c.kind = K_CLEAR;
		else if (pick < 62)
			c.kind = K_ROT_CCW;
		else if (pick < 74)
			c.kind = K_ROT_CW;
		else if (pick < 97)
			c.kind = K_SHOW;
		else
			c.kind = pick[0] ? KIND_RSVD_HI : KIND_RSVD_LO;
		// mostly indexes in use, some beyond
		if ($urandom_range(3, 0) != 0)
			c.idx = $urandom_range(shadow_count - 1, 0);
		else
			c.idx = $urandom_range(15, 0);
		c.rgb = $urandom;
		if ($urandom_range(9, 0) == 0)
			c.lvl = $urandom_range(127, 101);
		else
			c.lvl = $urandom_range(100, 0);
		c.gbright = $urandom_range(31, 0);
		return c;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_cmd(cmd_on_bus);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					cmd_on_bus = cmd_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cmd_on_bus.gbright, cmd_on_bus.lvl, cmd_on_bus.rgb,
						cmd_on_bus.idx};
					s_axis_tuser <= cmd_on_bus.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (words_due.size() == 0) begin
					fail_count++;
					$error("frame_word: expected none, got 0x%0h", m_axis_tdata[31:0]);
				end else begin
					due_word = words_due.pop_front();
					check_field("frame_word", due_word.word, m_axis_tdata[31:0]);
					check_field("byte_count", 32'(due_word.nbytes), 32'(m_axis_tdata[34:32]));
					check_field("last", 32'(due_word.last), 32'(m_axis_tlast));
					check_field("status", 32'(due_word.status), 32'(m_axis_tdata[36:35]));
				end
			end
			m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// wait for the block to go quiet, then let any item without a result finish
	task automatic settle();
		int waited;
		waited = 0;
		while ((cmd_backlog.size() != 0 || s_axis_tvalid || words_due.size() != 0)
				&& waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_led_count(logic [4:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (v == 0)
			shadow_count = 1;
		else if (v > STRIP_MAX)
			shadow_count = STRIP_MAX;
		else
			shadow_count = v;
	endtask

	initial begin
		logic [4:0] phase_cfg [8];
		phase_cfg = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd9, 5'd14};
		for (int i = 0; i < STRIP_MAX; i++)
			shadow_colours[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset led_count of 12
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd31);
		queue_cmd(K_SET_ONE, 4'd0, 24'hffffff, 7'd100, 5'd0);
		queue_cmd(K_SET_ONE, 4'd1, 24'h963296, 7'd20, 5'd0);   // exact ties
		queue_cmd(K_SET_ONE, 4'd2, 24'h123456, 7'd0, 5'd0);
		queue_cmd(K_SET_ONE, 4'd11, 24'hffffff, 7'd1, 5'd0);
		queue_cmd(K_SET_ONE, 4'd12, 24'habcdef, 7'd50, 5'd0);
		queue_cmd(K_SET_ONE, 4'd15, 24'habcdef, 7'd127, 5'd0);  // both faults
		queue_cmd(K_SET_ONE, 4'd3, 24'habcdef, 7'd101, 5'd0);
		queue_cmd(K_SET_ALL, 4'd0, 24'hffffff, 7'd127, 5'd0);
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd0);
		queue_cmd(K_ROT_CCW, 4'd0, 24'h0, 7'd0, 5'd0);
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd10);
		queue_cmd(K_ROT_CW, 4'd0, 24'h0, 7'd0, 5'd0);
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd21);
		queue_cmd(KIND_RSVD_LO, 4'd15, 24'hffffff, 7'd127, 5'd31);
		queue_cmd(KIND_RSVD_HI, 4'd15, 24'hffffff, 7'd127, 5'd31);
		queue_cmd(K_SET_ALL, 4'd0, 24'h80c040, 7'd50, 5'd0);
		queue_cmd(K_SET_ONE, 4'd5, 24'hff00ff, 7'd99, 5'd0);
		queue_cmd(K_ROT_CW, 4'd0, 24'h0, 7'd0, 5'd0);
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd31);
		queue_cmd(K_CLEAR, 4'd0, 24'h0, 7'd0, 5'd0);
		queue_cmd(K_SHOW, 4'd0, 24'h0, 7'd0, 5'd7);
		settle();

		for (int p = 0; p < 8; p++) begin
			write_led_count(phase_cfg[p]);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 77;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 77;
				end
				default: begin
					idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			for (int i = 0; i < 17; i++)
				cmd_backlog.push_back(rand_cmd());
			settle();
		end

		if (words_due.size() != 0) begin
			fail_count++;
			$error("frame_word: %0d expected items never arrived", words_due.size());
		end
		if (fail_count == 0)
			$display("led_strip_frame_engine_core verification clean");
		else
			$display("led_strip_frame_engine_core verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("led_strip_frame_engine_core verification failed");
		$finish;
	end

endmodule
